@@ hw/rtl/rcdt_pkg.sv @@
// shared types and constants for the reverse-cdt gaussian magnitude sampler
// holds the cumulative table, limb widths and the per-cell payload struct
// no dependencies
package rcdt_pkg;

  localparam int WORD_W             = 32;
  localparam int LIMB_W             = 31;
  localparam int MAG_W              = 5;
  localparam int TABLE_CAPACITY     = 32;
  localparam int TABLE_ROWS_DEFAULT = 22;
  localparam int LIVE_ROWS          = 22;

  // each entry is {high, mid, low}; rows past the live ones are zero
  localparam logic [3*WORD_W-1:0] CDT_TABLE [TABLE_CAPACITY] = '{
    {32'h556D69B6, 32'h4E73D911, 32'h0204FE5F},
    {32'h2FDB7191, 32'h1BCB49D6, 32'h7624991F},
    {32'h16091DCD, 32'h7DB923CB, 32'h26A118E0},
    {32'h0836DCFD, 32'h536A5628, 32'h70C18AE5},
    {32'h0273E65E, 32'h3D589AD0, 32'h54119E8D},
    {32'h00950CA4, 32'h2EBE8BE2, 32'h2EB0249E},
    {32'h001BFA1D, 32'h65A6660A, 32'h0472F0EC},
    {32'h000422EE, 32'h5945CB2D, 32'h70C91274},
    {32'h00007AFA, 32'h4A81EF20, 32'h0517A411},
    {32'h00000B31, 32'h79C6FA82, 32'h3A4CC14B},
    {32'h000000CC, 32'h185517F0, 32'h12B0F081},
    {32'h0000000B, 32'h2FB676CE, 32'h6073B7BE},
    {32'h00000000, 32'h3F53D508, 32'h1F24D098},
    {32'h00000000, 32'h02267C01, 32'h5FBBC714},
    {32'h00000000, 32'h000E9522, 32'h0A24AB07},
    {32'h00000000, 32'h00004D1E, 32'h61E4FCE8},
    {32'h00000000, 32'h0000013D, 32'h7B65A4CB},
    {32'h00000000, 32'h00000003, 32'h7EE574B9},
    {32'h00000000, 32'h00000000, 32'h04FF6C73},
    {32'h00000000, 32'h00000000, 32'h0009C080},
    {32'h00000000, 32'h00000000, 32'h00000ED2},
    {32'h00000000, 32'h00000000, 32'h00000011},
    {32'h00000000, 32'h00000000, 32'h00000000},
    {32'h00000000, 32'h00000000, 32'h00000000},
    {32'h00000000, 32'h00000000, 32'h00000000},
    {32'h00000000, 32'h00000000, 32'h00000000},
    {32'h00000000, 32'h00000000, 32'h00000000},
    {32'h00000000, 32'h00000000, 32'h00000000},
    {32'h00000000, 32'h00000000, 32'h00000000},
    {32'h00000000, 32'h00000000, 32'h00000000},
    {32'h00000000, 32'h00000000, 32'h00000000},
    {32'h00000000, 32'h00000000, 32'h00000000}
  };

  typedef struct packed {
    logic [LIMB_W-1:0] lo;
    logic [LIMB_W-1:0] mi;
    logic [LIMB_W-1:0] hi;
    logic [MAG_W-1:0]  count;
  } cell_data_t;

endpackage

@@ hw/rtl/rcdt_if.sv @@
// valid/ready channel interfaces for the sampler
// input beat carries three random words, output beat carries the magnitude
// depends on rcdt_pkg
interface rcdt_in_if import rcdt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_low;
  logic [WORD_W-1:0] random_mid;
  logic [WORD_W-1:0] random_high;

  modport source (output valid, output random_low, output random_mid,
                  output random_high, input ready);
  modport sink (input valid, input random_low, input random_mid,
                input random_high, output ready);
endinterface

interface rcdt_out_if import rcdt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] sample_magnitude;

  modport source (output valid, output sample_magnitude, input ready);
  modport sink (input valid, input sample_magnitude, output ready);
endinterface

@@ hw/rtl/rcdt_gaussian_magnitude_sampler_top.sv @@
// top level of the reverse-cdt gaussian magnitude sampler
// a row of rcdt_cell stages, one per table row; depends on rcdt_pkg and rcdt_if
//
// usage
//   sample_in: one beat carries random_low, random_mid and random_high; bit 31 of
//   each word is dropped, leaving three 31-bit limbs of a 93-bit uniform value
//   sample_out: one beat carries sample_magnitude, the number of table rows the
//   value falls below (0 to 22)
//   each cell compares the value against one table row and passes the limbs and
//   the running count to its neighbor through its register, so an output beat is
//   offered once its beat has passed through the register of every cell in turn
//   throughput is one beat per cycle while unstalled, set by the single register per cell
//   every cell holds its beat while the next one is full and stalled, so a
//   stalled receiver backs the chain up one cell at a time; empty cells keep
//   accepting until the whole chain is full
//   reset clears every cell valid; no beat is offered in the cycle after reset
//   there is no configuration and no other state
module rcdt_gaussian_magnitude_sampler_top import rcdt_pkg::*; #(
  parameter int TABLE_ROWS = TABLE_ROWS_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  rcdt_in_if.sink    sample_in,
  rcdt_out_if.source sample_out
);

  localparam int ROWS_USED = (TABLE_ROWS > TABLE_CAPACITY) ? TABLE_CAPACITY : TABLE_ROWS;

  logic       cell_valid [ROWS_USED+1];
  logic       cell_ready [ROWS_USED+1];
  cell_data_t cell_data  [ROWS_USED+1];

  assign cell_data[0] = '{lo:    sample_in.random_low[LIMB_W-1:0],
                          mi:    sample_in.random_mid[LIMB_W-1:0],
                          hi:    sample_in.random_high[LIMB_W-1:0],
                          count: '0};

  assign cell_valid[0]   = sample_in.valid;
  assign sample_in.ready = cell_ready[0];

  for (genvar r = 0; r < ROWS_USED; r++) begin : g_cell
    rcdt_cell #(
      .ROW_INDEX (r)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (cell_valid[r]),
      .up_ready (cell_ready[r]),
      .up_data  (cell_data[r]),
      .dn_valid (cell_valid[r+1]),
      .dn_ready (cell_ready[r+1]),
      .dn_data  (cell_data[r+1])
    );
  end

  assign sample_out.valid            = cell_valid[ROWS_USED];
  assign sample_out.sample_magnitude = cell_data[ROWS_USED].count;
  assign cell_ready[ROWS_USED]       = sample_out.ready;

  a_mag_range : assert property (@(posedge clk) disable iff (rst)
    sample_out.valid |-> (sample_out.sample_magnitude <= MAG_W'(LIVE_ROWS)))
    else $error("magnitude beyond live table rows");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !sample_out.valid)
    else $error("output beat offered right after reset");

  a_last_cell_room : assert property (@(posedge clk) disable iff (rst)
    !sample_out.valid |-> cell_ready[ROWS_USED-1])
    else $error("last cell stalled with empty output");

endmodule

@@ hw/rtl/rcdt_cell.sv @@
// one table-row cell: borrow chain against its row, count update, one register stage
// depends on rcdt_pkg
module rcdt_cell import rcdt_pkg::*; #(
  parameter int ROW_INDEX = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       up_valid,
  output logic       up_ready,
  input  cell_data_t up_data,
  output logic       dn_valid,
  input  logic       dn_ready,
  output cell_data_t dn_data
);

  localparam logic [3*WORD_W-1:0] ROW = CDT_TABLE[ROW_INDEX];

  logic              vld;
  cell_data_t        data;
  cell_data_t        data_next;
  logic              b_lo;
  logic              b_mi;
  logic              b_hi;
  logic [WORD_W-1:0] d_mi;
  logic [WORD_W-1:0] d_hi;

  always_comb begin
    b_lo = {1'b0, up_data.lo} < ROW[WORD_W-1:0];
    d_mi = {1'b0, up_data.mi} - WORD_W'(b_lo);
    b_mi = d_mi < ROW[2*WORD_W-1:WORD_W];
    d_hi = {1'b0, up_data.hi} - WORD_W'(b_mi);
    b_hi = d_hi < ROW[3*WORD_W-1:2*WORD_W];
    data_next       = up_data;
    data_next.count = up_data.count + MAG_W'(b_hi);
  end

  assign up_ready = !vld || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (up_ready) begin
      vld <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      data <= data_next;
    end
  end

  assign dn_valid = vld;
  assign dn_data  = data;

endmodule
